### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check at every edge, reset included
`define ASSERT_CLK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_NR(lbl, prop, msg)
`endif

`endif

### hw/rtl/cddu_pkg.sv
// ----------------------------------------------------------------------------
// cddu_pkg
// Types, codes, control program and calendar tables of the date difference unit.
// ----------------------------------------------------------------------------
package cddu_pkg;

  typedef logic [4:0]  day_t;
  typedef logic [3:0]  month_t;
  typedef logic [1:0]  order_t;
  typedef logic [21:0] dist_t;

  localparam order_t ORD_EQUAL         = 2'd0;
  localparam order_t ORD_FIRST_LATER   = 2'd1;
  localparam order_t ORD_FIRST_EARLIER = 2'd2;

  localparam dist_t DIST_MAX = 22'h3FFFFF;

  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 11;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MOD400    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COPY100   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MOD100    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LEAP_E    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_YEAR      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LEAP_L    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ADD_LATE  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SUB_EARLY = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ABS       = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD400,
    OP_COPY100,
    OP_MOD100,
    OP_LEAP_E,
    OP_YEAR,
    OP_LEAP_L,
    OP_ADD_LATE,
    OP_SUB_EARLY,
    OP_ABS,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_GE400,
    C_GE100,
    C_YNE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t w;
    case (s)
      STEP_IDLE:      w = '{op: OP_LOAD,      cond: C_NO_IN,    target: STEP_IDLE,   last: 1'b0};
      STEP_MOD400:    w = '{op: OP_MOD400,    cond: C_GE400,    target: STEP_MOD400, last: 1'b0};
      STEP_COPY100:   w = '{op: OP_COPY100,   cond: C_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_MOD100:    w = '{op: OP_MOD100,    cond: C_GE100,    target: STEP_MOD100, last: 1'b0};
      STEP_LEAP_E:    w = '{op: OP_LEAP_E,    cond: C_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_YEAR:      w = '{op: OP_YEAR,      cond: C_YNE,      target: STEP_YEAR,   last: 1'b0};
      STEP_LEAP_L:    w = '{op: OP_LEAP_L,    cond: C_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_ADD_LATE:  w = '{op: OP_ADD_LATE,  cond: C_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_SUB_EARLY: w = '{op: OP_SUB_EARLY, cond: C_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_ABS:       w = '{op: OP_ABS,       cond: C_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: STEP_EMIT,   last: 1'b1};
      default:        w = '{op: OP_NONE,      cond: C_NEVER,    target: STEP_IDLE,   last: 1'b1};
    endcase
    return w;
  endfunction

  // days in the months before m; months past twelve count as 30 days
  function automatic logic [8:0] month_prefix(input month_t m, input logic leap);
    logic [8:0] p;
    case (m)
      4'd0:    p = 9'd0;
      4'd1:    p = 9'd0;
      4'd2:    p = 9'd31;
      4'd3:    p = 9'd59;
      4'd4:    p = 9'd90;
      4'd5:    p = 9'd120;
      4'd6:    p = 9'd151;
      4'd7:    p = 9'd181;
      4'd8:    p = 9'd212;
      4'd9:    p = 9'd243;
      4'd10:   p = 9'd273;
      4'd11:   p = 9'd304;
      4'd12:   p = 9'd334;
      4'd13:   p = 9'd365;
      4'd14:   p = 9'd395;
      default: p = 9'd425;
    endcase
    if (leap && (m > 4'd2)) begin
      p = p + 9'd1;
    end
    return p;
  endfunction

  function automatic day_t month_length(input month_t m, input logic leap);
    day_t n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
               n = 5'd31;
      default: n = 5'd30;
    endcase
    return n;
  endfunction

  function automatic logic date_valid(input day_t d, input month_t m, input logic leap);
    logic ok;
    ok = (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= month_length(m, leap));
    return ok;
  endfunction

endpackage

### hw/rtl/calendar_date_difference_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_difference_unit
// Gregorian day count between two dates, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Takes one word holding two dates and returns one word with a validity and a
// leap flag for each date, their order and the absolute number of days between
// them (saturated to 22 bits). The early year is reduced modulo 400, then
// modulo 100, by one subtraction per cycle; then the unit steps year by year
// over the years between the dates, adding 365 or 366 into a single
// accumulator. A stalled result holds the emit step. The next word is taken
// once the previous result sits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_difference_unit #(
  parameter int YEAR_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cddu_pkg::day_t         first_day_i,
  input  cddu_pkg::month_t       first_month_i,
  input  logic [YEAR_BITS-1:0]   first_year_i,
  input  cddu_pkg::day_t         second_day_i,
  input  cddu_pkg::month_t       second_month_i,
  input  logic [YEAR_BITS-1:0]   second_year_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   first_valid_o,
  output logic                   second_valid_o,
  output logic                   first_leap_o,
  output logic                   second_leap_o,
  output cddu_pkg::order_t       order_o,
  output cddu_pkg::dist_t        day_distance_o
);

  import cddu_pkg::*;

  localparam int AccW = (YEAR_BITS + 11 > 24) ? (YEAR_BITS + 11) : 24;

  logic [STEP_W-1:0]    step_q, step_d;
  ctrl_t                ctl;
  logic                 out_valid_q;
  logic                 in_fire, out_busy, emit_fire, jump, leap_now;

  order_t               ord_in;
  logic                 swap_in;

  day_t                 d_e_q, d_l_q;
  month_t               m_e_q, m_l_q;
  logic [YEAR_BITS-1:0] ycur_q, ylate_q, r400_q;
  logic [8:0]           r100_q;
  logic                 leap_e_q, leap_l_q, swap_q;
  order_t               ord_q;
  logic [AccW-1:0]      acc_q;

  logic                 f_valid_q, s_valid_q, f_leap_q, s_leap_q;
  order_t               ord_out_q;
  dist_t                dist_q;

  logic                 f_leap, s_leap;
  day_t                 f_day, s_day;
  month_t               f_mon, s_mon;

  assign ctl       = ucode(step_q);
  assign in_ready_o = (ctl.op == OP_LOAD);
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_busy  = out_valid_q && !out_ready_i;
  assign emit_fire = (ctl.op == OP_EMIT) && !out_busy;
  assign leap_now  = (ycur_q[1:0] == 2'b00) && ((r100_q != '0) || (r400_q == '0));

  always_comb begin
    if (first_year_i != second_year_i) begin
      ord_in = (first_year_i > second_year_i) ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
    end else if (first_month_i != second_month_i) begin
      ord_in = (first_month_i > second_month_i) ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
    end else if (first_day_i != second_day_i) begin
      ord_in = (first_day_i > second_day_i) ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
    end else begin
      ord_in = ORD_EQUAL;
    end
  end

  assign swap_in = (ord_in == ORD_FIRST_LATER);

  always_comb begin
    case (ctl.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_IN:    jump = !in_fire;
      C_GE400:    jump = (r400_q >= YEAR_BITS'(400));
      C_GE100:    jump = (r100_q >= 9'd100);
      C_YNE:      jump = (ycur_q != ylate_q);
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b0;
    endcase
    if (jump) begin
      step_d = ctl.target;
    end else if (ctl.last) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign f_leap = swap_q ? leap_l_q : leap_e_q;
  assign s_leap = swap_q ? leap_e_q : leap_l_q;
  assign f_day  = swap_q ? d_l_q : d_e_q;
  assign s_day  = swap_q ? d_e_q : d_l_q;
  assign f_mon  = swap_q ? m_l_q : m_e_q;
  assign s_mon  = swap_q ? m_e_q : m_l_q;

  always_ff @(posedge clk_i) begin
    case (ctl.op)
      OP_LOAD: begin
        if (in_fire) begin
          ord_q   <= ord_in;
          swap_q  <= swap_in;
          d_e_q   <= swap_in ? second_day_i   : first_day_i;
          m_e_q   <= swap_in ? second_month_i : first_month_i;
          d_l_q   <= swap_in ? first_day_i    : second_day_i;
          m_l_q   <= swap_in ? first_month_i  : second_month_i;
          ycur_q  <= swap_in ? second_year_i  : first_year_i;
          r400_q  <= swap_in ? second_year_i  : first_year_i;
          ylate_q <= swap_in ? first_year_i   : second_year_i;
          acc_q   <= '0;
        end
      end
      OP_MOD400: begin
        if (r400_q >= YEAR_BITS'(400)) begin
          r400_q <= r400_q - YEAR_BITS'(400);
        end
      end
      OP_COPY100: begin
        r100_q <= r400_q[8:0];
      end
      OP_MOD100: begin
        if (r100_q >= 9'd100) begin
          r100_q <= r100_q - 9'd100;
        end
      end
      OP_LEAP_E: begin
        leap_e_q <= leap_now;
      end
      OP_YEAR: begin
        if (ycur_q != ylate_q) begin
          acc_q  <= acc_q + AccW'(365) + AccW'(leap_now);
          ycur_q <= ycur_q + YEAR_BITS'(1);
          r400_q <= (r400_q == YEAR_BITS'(399)) ? '0 : r400_q + YEAR_BITS'(1);
          r100_q <= (r100_q == 9'd99) ? '0 : r100_q + 9'd1;
        end
      end
      OP_LEAP_L: begin
        leap_l_q <= leap_now;
      end
      OP_ADD_LATE: begin
        acc_q <= acc_q + AccW'(month_prefix(m_l_q, leap_l_q)) + AccW'(d_l_q);
      end
      OP_SUB_EARLY: begin
        acc_q <= acc_q - AccW'(month_prefix(m_e_q, leap_e_q)) - AccW'(d_e_q);
      end
      OP_ABS: begin
        if (acc_q[AccW-1]) begin
          acc_q <= ~acc_q + AccW'(1);
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          f_valid_q <= date_valid(f_day, f_mon, f_leap);
          s_valid_q <= date_valid(s_day, s_mon, s_leap);
          f_leap_q  <= f_leap;
          s_leap_q  <= s_leap;
          ord_out_q <= ord_q;
          dist_q    <= (acc_q > AccW'(DIST_MAX)) ? DIST_MAX : acc_q[21:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign first_valid_o  = f_valid_q;
  assign second_valid_o = s_valid_q;
  assign first_leap_o   = f_leap_q;
  assign second_leap_o  = s_leap_q;
  assign order_o        = ord_out_q;
  assign day_distance_o = dist_q;

  `ASSERT_CLK(a_step_in_program, step_q < STEP_W'(NUM_STEPS), "step counter left the program")
  `ASSERT_CLK(a_out_from_emit, $rose(out_valid_q) |-> $past(ctl.op == OP_EMIT), "result without emit step")
  `ASSERT_CLK(a_year_bounds, (ctl.op == OP_YEAR) |-> ((ycur_q <= ylate_q) && (r400_q < YEAR_BITS'(400)) && (r100_q < 9'd100)), "year walk out of range")
  `ASSERT_CLK(a_emit_nonneg, (ctl.op == OP_EMIT) |-> !acc_q[AccW-1], "distance negative at emit")

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for calendar_date_difference_unit. A short table of
// date pairs covers leap rules, year zero, month zero, months past twelve,
// out-of-range days, negative spans, equal dates and saturation. A random
// mix of well-formed and malformed date pairs follows. Every result is compared
// to the table or a behavioral day counter, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cddu_pkg::*;

  localparam int YEAR_W         = 14;
  localparam int RANDOM_WORDS   = 100;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES   = 64;

  typedef logic [YEAR_W-1:0] year_t;

  typedef struct {
    day_t   d1;
    month_t m1;
    year_t  y1;
    day_t   d2;
    month_t m2;
    year_t  y2;
  } date_pair_t;

  typedef struct {
    logic   v1;
    logic   v2;
    logic   l1;
    logic   l2;
    order_t ord;
    dist_t  days;
  } day_count_t;

  typedef struct {
    date_pair_t dates;
    bit         typed;
    day_count_t want;
  } dir_row_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid      = 1'b0;
  day_t   first_day     = '0;
  month_t first_month   = '0;
  year_t  first_year    = '0;
  day_t   second_day    = '0;
  month_t second_month  = '0;
  year_t  second_year   = '0;
  logic   out_ready     = 1'b0;
  logic   in_ready_o;
  logic   out_valid_o;
  logic   first_valid_o;
  logic   second_valid_o;
  logic   first_leap_o;
  logic   second_leap_o;
  order_t order_o;
  dist_t  day_distance_o;

  day_count_t pending_counts[$];
  dir_row_t   dir_table[$];
  bit         calm          = 1'b0;
  int         mismatches    = 0;
  int         results_seen  = 0;
  int         words_sent    = 0;
  int         invalid_words = 0;
  int         stall_cycles  = 0;

  calendar_date_difference_unit #(
    .YEAR_BITS(YEAR_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .first_day_i    (first_day),
    .first_month_i  (first_month),
    .first_year_i   (first_year),
    .second_day_i   (second_day),
    .second_month_i (second_month),
    .second_year_i  (second_year),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .first_valid_o  (first_valid_o),
    .second_valid_o (second_valid_o),
    .first_leap_o   (first_leap_o),
    .second_leap_o  (second_leap_o),
    .order_o        (order_o),
    .day_distance_o (day_distance_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit is_leap(input year_t y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int days_in_month(input int m, input bit leap);
    if (m == 2) return leap ? 29 : 28;
    if (m == 1 || m == 3 || m == 5 || m == 7 || m == 8 || m == 10 || m == 12) return 31;
    return 30;
  endfunction

  function automatic longint ordinal_in_year(input day_t d, input month_t m, input bit leap);
    longint sum;
    sum = longint'(d);
    for (int i = 1; i < int'(m); i++) begin
      sum += days_in_month(i, leap);
    end
    return sum;
  endfunction

  function automatic longint days_to_year(input year_t y);
    longint n;
    longint p;
    if (y == 0) return 0;
    n = longint'(y);
    p = n - 1;
    return n * 365 + p / 4 - p / 100 + p / 400 + 1;
  endfunction

  function automatic bit calendar_ok(input day_t d, input month_t m, input bit leap);
    if (m < 1 || m > 12) return 1'b0;
    return d >= 1 && int'(d) <= days_in_month(int'(m), leap);
  endfunction

  function automatic day_count_t count_days(input date_pair_t w);
    day_count_t r;
    longint     q1;
    longint     q2;
    longint     span;
    r.l1 = is_leap(w.y1);
    r.l2 = is_leap(w.y2);
    r.v1 = calendar_ok(w.d1, w.m1, r.l1);
    r.v2 = calendar_ok(w.d2, w.m2, r.l2);
    q1 = ordinal_in_year(w.d1, w.m1, r.l1);
    q2 = ordinal_in_year(w.d2, w.m2, r.l2);
    if (w.y1 != w.y2) r.ord = (w.y1 > w.y2) ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
    else if (w.m1 != w.m2) r.ord = (w.m1 > w.m2) ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
    else if (w.d1 != w.d2) r.ord = (w.d1 > w.d2) ? ORD_FIRST_LATER : ORD_FIRST_EARLIER;
    else r.ord = ORD_EQUAL;
    span = 0;
    if (r.ord == ORD_FIRST_LATER) span = q1 - q2 + days_to_year(w.y1) - days_to_year(w.y2);
    else if (r.ord == ORD_FIRST_EARLIER)
      span = q2 - q1 + days_to_year(w.y2) - days_to_year(w.y1);
    if (span < 0) span = -span;
    r.days = (span > longint'(DIST_MAX)) ? DIST_MAX : dist_t'(span);
    return r;
  endfunction

  task automatic add_row(input int d1, input int m1, input int y1, input int d2, input int m2,
                         input int y2, input bit typed, input bit v1 = 0, input bit v2 = 0,
                         input bit l1 = 0, input bit l2 = 0, input order_t ord = ORD_EQUAL,
                         input dist_t days = '0);
    dir_row_t row;
    row.dates = '{d1: day_t'(d1), m1: month_t'(m1), y1: year_t'(y1),
                  d2: day_t'(d2), m2: month_t'(m2), y2: year_t'(y2)};
    row.typed = typed;
    row.want  = '{v1: v1, v2: v2, l1: l1, l2: l2, ord: ord, days: days};
    dir_table.push_back(row);
  endtask

  task automatic send_dates(input date_pair_t w, input bit typed, input day_count_t want);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    first_day    <= w.d1;
    first_month  <= w.m1;
    first_year   <= w.y1;
    second_day   <= w.d2;
    second_month <= w.m2;
    second_year  <= w.y2;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_counts.push_back(typed ? want : count_days(w));
    words_sent++;
    if (!calendar_ok(w.d1, w.m1, is_leap(w.y1)) || !calendar_ok(w.d2, w.m2, is_leap(w.y2)))
      invalid_words++;
  endtask

  function automatic year_t near_year(input year_t y, input int top);
    int v;
    v = int'(y) + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return year_t'(v);
  endfunction

  function automatic date_pair_t random_dates();
    date_pair_t w;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      w.y1 = year_t'($urandom_range(0, 9999));
      w.y2 = ($urandom_range(0, 9) == 0) ? w.y1 : near_year(w.y1, 9999);
      w.m1 = month_t'($urandom_range(1, 12));
      w.m2 = ($urandom_range(0, 4) == 0) ? w.m1 : month_t'($urandom_range(1, 12));
      w.d1 = day_t'($urandom_range(1, days_in_month(int'(w.m1), is_leap(w.y1))));
      w.d2 = day_t'($urandom_range(1, days_in_month(int'(w.m2), is_leap(w.y2))));
      if ($urandom_range(0, 19) == 0) begin
        w.y2 = w.y1;
        w.m2 = w.m1;
        w.d2 = w.d1;
      end
    end else begin
      w.d1 = day_t'($urandom_range(0, 31));
      w.m1 = month_t'($urandom_range(0, 15));
      w.d2 = day_t'($urandom_range(0, 31));
      w.m2 = month_t'($urandom_range(0, 15));
      if (kind < 90) begin
        w.y1 = year_t'($urandom_range(0, 9999));
        w.y2 = near_year(w.y1, 9999);
      end else if (kind < 97) begin
        w.y1 = year_t'($urandom_range(0, 9999));
        w.y2 = year_t'($urandom_range(0, 9999));
      end else begin
        w.y1 = year_t'($urandom_range(9999, 16383));
        w.y2 = near_year(w.y1, 16383);
      end
    end
    return w;
  endfunction

  task automatic check_count(input day_count_t got);
    day_count_t want;
    if (pending_counts.size() == 0) begin
      if (mismatches < 10) $display("unexpected result: order %0d distance %0d", got.ord, got.days);
      mismatches++;
      return;
    end
    want = pending_counts.pop_front();
    results_seen++;
    if (got.v1 !== want.v1 || got.v2 !== want.v2 || got.l1 !== want.l1 ||
        got.l2 !== want.l2 || got.ord !== want.ord || got.days !== want.days) begin
      if (mismatches < 10) begin
        $display("mismatch on result %0d: valid %b%b leap %b%b order %0d dist %0d,",
                 results_seen, got.v1, got.v2, got.l1, got.l2, got.ord, got.days);
        $display("  expected %b%b %b%b %0d %0d",
                 want.v1, want.v2, want.l1, want.l2, want.ord, want.days);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      check_count('{v1: first_valid_o, v2: second_valid_o, l1: first_leap_o,
                    l2: second_leap_o, ord: order_o, days: day_distance_o});
    end
    out_ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 stall_cycles, pending_counts.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    day_count_t none;
    none = '{v1: 0, v2: 0, l1: 0, l2: 0, ord: ORD_EQUAL, days: '0};
    add_row(1, 1, 2000, 1, 1, 2000, 1, 1, 1, 1, 1, ORD_EQUAL, 0);
    add_row(29, 2, 0, 1, 3, 0, 1, 1, 1, 1, 1, ORD_FIRST_EARLIER, 1);
    add_row(0, 0, 0, 1, 1, 0, 1, 0, 1, 1, 1, ORD_FIRST_EARLIER, 1);
    add_row(1, 1, 0, 1, 1, 16383, 1, 1, 1, 1, 0, ORD_FIRST_EARLIER, DIST_MAX);
    add_row(31, 15, 16383, 0, 0, 0, 1, 0, 0, 0, 1, ORD_FIRST_LATER, DIST_MAX);
    add_row(1, 3, 1900, 1, 3, 1901, 1, 1, 1, 0, 0, ORD_FIRST_EARLIER, 365);
    add_row(1, 1, 2100, 1, 1, 2101, 1, 1, 1, 0, 0, ORD_FIRST_EARLIER, 365);
    add_row(1, 1, 2024, 31, 12, 2023, 1, 1, 1, 1, 0, ORD_FIRST_LATER, 1);
    add_row(29, 2, 2004, 28, 2, 2004, 1, 1, 1, 1, 1, ORD_FIRST_LATER, 1);
    add_row(15, 6, 9999, 15, 6, 9999, 1, 1, 1, 0, 0, ORD_EQUAL, 0);
    add_row(29, 2, 1900, 29, 2, 2000, 0);
    add_row(30, 2, 2024, 1, 3, 2024, 0);
    add_row(31, 4, 2001, 0, 5, 2001, 0);
    add_row(1, 15, 2001, 31, 12, 2001, 0);
    add_row(31, 13, 2001, 1, 14, 2001, 0);
    add_row(0, 12, 8191, 31, 8, 8191, 0);
    add_row(31, 1, 2400, 31, 1, 2399, 0);
    add_row(1, 1, 1, 31, 12, 9999, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_dates(dir_table[i].dates, dir_table[i].typed, dir_table[i].want);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 40 && i < 70);
      send_dates(random_dates(), 1'b0, none);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words (%0d table rows, %0d random), %0d with an invalid date",
             words_sent, dir_table.size(), RANDOM_WORDS, invalid_words);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/cddu_pkg.sv
hw/rtl/calendar_date_difference_unit.sv
sim/tb.sv
